@@ design/mrq_pkg.sv @@
`default_nettype none
package mrq_pkg;
  localparam int DEPTH = 16;
  localparam int SUBS = 8;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(SUBS);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_BACK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DROPPED = 3'd2,
    ST_NODATA  = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_DROP        = 2'd1;
  localparam logic [1:0] REG_MASK        = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_DECIDE, S_GOT, S_SHRD, S_SHWR, S_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    entry_t        data;
  } ram_wr_t;
endpackage
`default_nettype wire

@@ design/mrq_entry_ram.sv @@
`default_nettype none
module mrq_entry_ram
  import mrq_pkg::*;
(
  input  wire logic          clk,
  input  wire ram_wr_t       wr,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/multi_reader_queue_evict_oldest_free_core.sv @@
// channel   | dir | tdata (low bit up)                               | tuser
// s_axis    | in  | buffer_handle[15:0], stamp[79:16]                | opcode[1:0], subscriber[4:2]
// m_axis    | out | out_handle, out_stamp, released_valid,           | status[2:0]
//           |     | released_handle, release_count, cleared_count    |
// cfg       | in  | cfg_we, cfg_addr (register index), cfg_wdata     |
// one request at a time: push and step back pass dispatch and output, pull also a read.
// an eviction or clear goes through dispatch, the subscriber scan and the decision,
// then starts and ends the shift, reading and then writing back each moved entry.
// the result moves into the output register and the block returns to idle; a
// request waits in its last state while that register is still full.
// rst is synchronous; it clears count, indices, drop and mask and sets max_entries to 16.
`default_nettype none
module multi_reader_queue_evict_oldest_free_core
  import mrq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [87:0]  s_axis_tdata,  // buffer_handle, stamp
  input  wire logic [4:0]   s_axis_tuser,  // opcode, subscriber
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,  // out_handle, out_stamp, released_valid,
                                           // released_handle, release_count, cleared_count
  output logic [2:0]        m_axis_tuser,  // status
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [7:0]   cfg_wdata
);
  state_t state, state_next;

  logic [4:0]      max_entries;
  logic            drop_when_full;
  logic [SUBS-1:0] mask;

  logic [CW-1:0] count;
  logic [CW-1:0] ri [SUBS];

  op_t           op;
  logic [SW-1:0] sub;
  entry_t        inent;

  logic [SW-1:0] sc;
  logic [CW-1:0] acc_max, acc_min;
  logic [3:0]    nreg;
  logic [CW-1:0] ptr, gap;

  status_t     res_status;
  logic [15:0] res_oh;
  logic [63:0] res_os;
  logic        res_rv;
  logic [15:0] res_rh;
  logic [3:0]  res_rc;
  logic [4:0]  res_pc;

  ram_wr_t       wr;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic [CW-1:0] cap, ri_sel, popped;
  logic [CW:0]   rem, src;
  logic          st_we;
  status_t       st_val;

  mrq_entry_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (max_entries == 5'd0) begin
      cap = CW'(1);
    end else if (max_entries > 5'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = max_entries;
    end
  end

  // one index read port, shared by the scan and the per-request lookup
  assign ri_sel = ri[(state == S_SCAN) ? sc : sub];
  assign rem    = {1'b0, acc_max} + (CW+1)'(1);
  assign popped = (acc_min < count) ? acc_min : count;
  assign src    = {1'b0, ptr} + {1'b0, gap};
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    raddr      = '0;
    st_we      = 1'b0;
    st_val     = ST_OK;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_DISP;
      end
      S_DISP: begin
        if (op == OP_PUSH) begin
          if (count < cap) begin
            wr.we      = 1'b1;
            wr.addr    = count[AW-1:0];
            wr.data    = inent;
            state_next = S_OUT;
          end else if (!drop_when_full) begin
            st_we      = 1'b1;
            st_val     = ST_FULL;
            state_next = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end else if (!mask[sub]) begin
          st_we      = 1'b1;
          st_val     = ST_UNKNOWN;
          state_next = S_OUT;
        end else if (op == OP_PULL) begin
          if (ri_sel >= count) begin
            st_we      = 1'b1;
            st_val     = ST_NODATA;
            state_next = S_OUT;
          end else begin
            raddr      = ri_sel[AW-1:0];
            state_next = S_GOT;
          end
        end else if (op == OP_BACK) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sc == SW'(SUBS - 1)) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (op == OP_PUSH) begin
          if (rem >= {1'b0, count}) begin
            st_we      = 1'b1;
            st_val     = ST_DROPPED;
            state_next = S_OUT;
          end else begin
            raddr      = rem[AW-1:0];
            state_next = S_GOT;
          end
        end else if (popped == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_GOT: begin
        state_next = (op == OP_PULL) ? S_OUT : S_SHRD;
      end
      S_SHRD: begin
        if (src < {1'b0, count}) begin
          raddr      = src[AW-1:0];
          state_next = S_SHWR;
        end else begin
          if (op == OP_PUSH) begin
            // newest entry goes to the top slot after the shift
            wr.we   = 1'b1;
            wr.addr = AW'(count - CW'(1));
            wr.data = inent;
          end
          state_next = S_OUT;
        end
      end
      S_SHWR: begin
        wr.we      = 1'b1;
        wr.addr    = ptr[AW-1:0];
        wr.data    = rdata;
        state_next = S_SHRD;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and index state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries    <= 5'd16;
      drop_when_full <= 1'b0;
      mask           <= '0;
      count          <= '0;
      for (int s = 0; s < SUBS; s++) ri[s] <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_ENTRIES: max_entries <= cfg_wdata[4:0];
          REG_DROP:        drop_when_full <= cfg_wdata[0];
          REG_MASK: begin
            mask <= cfg_wdata[SUBS-1:0];
            for (int s = 0; s < SUBS; s++) begin
              if (cfg_wdata[s] && !mask[s]) ri[s] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_DISP: begin
          if (op == OP_PUSH && count < cap) count <= count + CW'(1);
          if (op == OP_BACK && mask[sub] && ri_sel != '0) ri[sub] <= ri_sel - CW'(1);
        end
        S_GOT: begin
          if (op == OP_PULL) ri[sub] <= ri_sel + CW'(1);
        end
        S_SHRD: begin
          if (src >= {1'b0, count} && op == OP_CLEAR) begin
            count <= count - gap;
            for (int s = 0; s < SUBS; s++) begin
              if (mask[s]) ri[s] <= (ri[s] > gap) ? ri[s] - gap : '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      op    <= op_t'(s_axis_tuser[1:0]);
      sub   <= s_axis_tuser[4:2];
      inent <= '{handle: s_axis_tdata[15:0], stamp: s_axis_tdata[79:16]};
    end
    if (st_we) res_status <= st_val;
    case (state)
      S_DISP: begin
        if (!st_we) res_status <= ST_OK;
        res_oh  <= '0;
        res_os  <= '0;
        res_rv  <= 1'b0;
        res_rh  <= '0;
        res_rc  <= '0;
        res_pc  <= '0;
        sc      <= '0;
        acc_max <= '0;
        acc_min <= cap;
        nreg    <= '0;
      end
      S_SCAN: begin
        if (mask[sc]) begin
          if (ri_sel > acc_max) acc_max <= ri_sel;
          if (ri_sel < acc_min) acc_min <= ri_sel;
          nreg <= nreg + 4'd1;
        end
        sc <= sc + SW'(1);
      end
      S_DECIDE: begin
        if (op == OP_PUSH) begin
          res_rv <= 1'b1;
          res_rc <= nreg;
          res_rh <= inent.handle;
          ptr    <= rem[CW-1:0];
          gap    <= CW'(1);
        end else begin
          res_pc <= 5'(popped);
          ptr    <= '0;
          gap    <= popped;
        end
      end
      S_GOT: begin
        if (op == OP_PULL) begin
          res_oh <= rdata.handle;
          res_os <= rdata.stamp;
        end else begin
          res_rh <= rdata.handle;
        end
      end
      S_SHWR: ptr <= ptr + CW'(1);
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tuser <= res_status;
          m_axis_tdata <= {6'd0, res_pc, res_rc, res_rh, res_rv, res_os, res_oh};
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ design/mrq_checker.sv @@
`default_nettype none
module mrq_props
  import mrq_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [87:0]  s_axis_tdata,
  input wire logic [4:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic [2:0]   m_axis_tuser,
  input wire logic         cfg_we,
  input wire logic [1:0]   cfg_addr,
  input wire logic [7:0]   cfg_wdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_release: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[80] |->
      (m_axis_tuser == ST_OK || m_axis_tuser == ST_DROPPED))
    else $error("release with wrong status");

  a_popped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[105:101] != 5'd0 |-> m_axis_tuser == ST_OK)
    else $error("clear count with error status");
endmodule

bind multi_reader_queue_evict_oldest_free_core mrq_props u_mrq_props (.*);
`default_nettype wire

@@ tb/mrq_checker.sv @@
module mrq_checker
  import mrq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [87:0]  s_axis_tdata,  // buffer_handle, stamp
  input  wire logic [4:0]   s_axis_tuser,  // opcode, subscriber
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [111:0] m_axis_tdata,  // out_handle, out_stamp, released_valid,
                                           // released_handle, release_count, cleared_count
  input  wire logic [2:0]   m_axis_tuser,  // status
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [7:0]   cfg_wdata,
  output int                errors,
  output int                pending,
  output int                responses
);

  typedef struct {
    status_t     status;
    logic [15:0] out_handle;
    logic [63:0] out_stamp;
    logic        released_valid;
    logic [15:0] released_handle;
    logic [3:0]  release_count;
    logic [4:0]  cleared_count;
  } response_t;

  response_t   expected_responses[$];
  logic [15:0] q_handle[DEPTH];
  logic [63:0] q_stamp[DEPTH];
  int          q_count;
  int          rd_idx[SUBS];
  logic [4:0]  max_entries;
  logic        drop_full;
  logic [7:0]  sub_mask;

  function automatic int capacity();
    if (max_entries == 0) return 1;
    if (max_entries > DEPTH) return DEPTH;
    return max_entries;
  endfunction

  task automatic predict_response(input op_t op, input int sub, input logic [15:0] h,
                                  input logic [63:0] st);
    response_t r;
    int far;
    int near;
    int rem;
    int n;
    r = '{ST_OK, 16'd0, 64'd0, 1'b0, 16'd0, 4'd0, 5'd0};
    if (op == OP_PUSH) begin
      if (q_count < capacity()) begin
        q_handle[q_count] = h;
        q_stamp[q_count] = st;
        q_count++;
      end else if (!drop_full) begin
        r.status = ST_FULL;
      end else begin
        far = 0;
        n = 0;
        for (int s = 0; s < SUBS; s++)
          if (sub_mask[s]) begin
            n++;
            if (rd_idx[s] > far) far = rd_idx[s];
          end
        rem = far + 1;
        r.released_valid = 1'b1;
        r.release_count = n[3:0];
        if (rem >= q_count) begin
          r.status = ST_DROPPED;
          r.released_handle = h;
        end else begin
          r.released_handle = q_handle[rem];
          for (int i = rem; i + 1 < q_count; i++) begin
            q_handle[i] = q_handle[i+1];
            q_stamp[i] = q_stamp[i+1];
          end
          q_handle[q_count-1] = h;
          q_stamp[q_count-1] = st;
        end
      end
    end else if (!sub_mask[sub]) begin
      r.status = ST_UNKNOWN;
    end else if (op == OP_PULL) begin
      if (rd_idx[sub] >= q_count) begin
        r.status = ST_NODATA;
      end else begin
        r.out_handle = q_handle[rd_idx[sub]];
        r.out_stamp = q_stamp[rd_idx[sub]];
        rd_idx[sub]++;
      end
    end else if (op == OP_BACK) begin
      if (rd_idx[sub] > 0) rd_idx[sub]--;
    end else begin
      near = capacity();
      for (int s = 0; s < SUBS; s++)
        if (sub_mask[s] && rd_idx[s] < near) near = rd_idx[s];
      n = near < q_count ? near : q_count;
      if (n > 0) begin
        for (int i = 0; i + n < q_count; i++) begin
          q_handle[i] = q_handle[i+n];
          q_stamp[i] = q_stamp[i+n];
        end
        q_count -= n;
        for (int s = 0; s < SUBS; s++)
          if (sub_mask[s]) rd_idx[s] = rd_idx[s] > n ? rd_idx[s] - n : 0;
      end
      r.cleared_count = n[4:0];
    end
    expected_responses.insert(expected_responses.size(), r);
  endtask

  task automatic compare_response();
    response_t e;
    if (expected_responses.size() == 0) begin
      $error("response with no request waiting");
      errors++;
      return;
    end
    e = expected_responses[0];
    expected_responses.delete(0);
    if (m_axis_tuser !== e.status) begin
      $error("status exp %0d got %0d", e.status, m_axis_tuser); errors++;
    end
    if (m_axis_tdata[15:0] !== e.out_handle) begin
      $error("out_handle exp %h got %h", e.out_handle, m_axis_tdata[15:0]); errors++;
    end
    if (m_axis_tdata[79:16] !== e.out_stamp) begin
      $error("out_stamp exp %h got %h", e.out_stamp, m_axis_tdata[79:16]); errors++;
    end
    if (m_axis_tdata[80] !== e.released_valid) begin
      $error("released_valid exp %0d got %0d", e.released_valid, m_axis_tdata[80]);
      errors++;
    end
    if (m_axis_tdata[96:81] !== e.released_handle) begin
      $error("released_handle exp %h got %h", e.released_handle, m_axis_tdata[96:81]);
      errors++;
    end
    if (m_axis_tdata[100:97] !== e.release_count) begin
      $error("release_count exp %0d got %0d", e.release_count, m_axis_tdata[100:97]);
      errors++;
    end
    if (m_axis_tdata[105:101] !== e.cleared_count) begin
      $error("cleared_count exp %0d got %0d", e.cleared_count, m_axis_tdata[105:101]);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      q_count = 0;
      for (int s = 0; s < SUBS; s++) rd_idx[s] = 0;
      max_entries = 5'd16;
      drop_full = 1'b0;
      sub_mask = 8'd0;
      expected_responses.delete();
      errors = 0;
      responses = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        compare_response();
        responses++;
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_response(op_t'(s_axis_tuser[1:0]), int'(s_axis_tuser[4:2]),
                         s_axis_tdata[15:0], s_axis_tdata[79:16]);
      if (cfg_we) begin
        if (cfg_addr == REG_MAX_ENTRIES) begin
          max_entries = cfg_wdata[4:0];
        end else if (cfg_addr == REG_DROP) begin
          drop_full = cfg_wdata[0];
        end else if (cfg_addr == REG_MASK) begin
          // newly registered slots start reading from the head
          for (int s = 0; s < SUBS; s++)
            if (cfg_wdata[s] && !sub_mask[s]) rd_idx[s] = 0;
          sub_mask = cfg_wdata;
        end
      end
    end
    pending = expected_responses.size();
  end

endmodule

@@ tb/multi_reader_queue_evict_oldest_free_core_tb.sv @@
module multi_reader_queue_evict_oldest_free_core_tb;
  import mrq_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata;   // buffer_handle, stamp
  logic [4:0]   s_axis_tuser;   // opcode, subscriber
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;   // out_handle, out_stamp, released_valid,
                                // released_handle, release_count, cleared_count
  logic [2:0]   m_axis_tuser;   // status
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [7:0]   cfg_wdata;
  int           errors;
  int           pending;
  int           responses;
  int           send_idle;
  int           recv_stall;
  int           hold_seq;
  int           requests;

  multi_reader_queue_evict_oldest_free_core dut (.*);

  mrq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAIL multi_reader_queue_evict_oldest_free_core");
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    int seen;
    int hold_left;
    seen = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_request(input op_t op, input int sub, input logic [15:0] h,
                              input logic [63:0] st);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {8'd0, st, h};
    s_axis_tuser <= {sub[2:0], op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests++;
    @(negedge clk);
  endtask

  // only while nothing is in flight
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int r;
    logic [63:0] st;
    r = $urandom_range(99);
    st = {$urandom, $urandom};
    if (r < 38) send_request(OP_PUSH, $urandom_range(7), 16'($urandom), st);
    else if (r < 72) send_request(OP_PULL, $urandom_range(7), 16'($urandom), st);
    else if (r < 84) send_request(OP_BACK, $urandom_range(7), 16'($urandom), st);
    else send_request(OP_CLEAR, $urandom_range(7), 16'($urandom), st);
  endtask

  initial begin
    logic [4:0] caps[8];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd8, 5'd2, 5'd12};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_seq = 0;
    requests = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unknown slot, fill, refuse, pull to empty, step back, clear
    send_request(OP_PULL, 0, 16'h0, 64'h0);
    send_request(OP_PUSH, 0, 16'hffff, '1);
    write_reg(REG_MAX_ENTRIES, 8'd4);
    write_reg(REG_MASK, 8'hff);
    send_request(OP_PUSH, 7, 16'h0000, 64'h0);
    send_request(OP_PUSH, 0, 16'h1234, 64'h8000_0000_0000_0001);
    send_request(OP_PUSH, 0, 16'h5678, 64'h0123_4567_89ab_cdef);
    send_request(OP_PUSH, 0, 16'h9abc, 64'hffff_0000_ffff_0000);
    for (int i = 0; i < 5; i++) send_request(OP_PULL, 3, 16'h0, 64'h0);
    send_request(OP_BACK, 3, 16'h0, 64'h0);
    send_request(OP_BACK, 0, 16'h0, 64'h0);
    send_request(OP_PULL, 0, 16'h0, 64'h0);
    send_request(OP_CLEAR, 0, 16'h0, 64'h0);
    write_reg(REG_DROP, 8'd1);
    send_request(OP_PUSH, 0, 16'haaaa, '1);
    send_request(OP_PULL, 5, 16'h0, 64'h0);
    send_request(OP_PUSH, 0, 16'h5555, 64'h0);
    // furthest reader at the tail drops the incoming handle
    for (int i = 0; i < 4; i++) send_request(OP_PULL, 3, 16'h0, 64'h0);
    send_request(OP_PUSH, 0, 16'hbeef, 64'h1);
    // no registered slots, then capacity lowered below fill
    write_reg(REG_MASK, 8'h00);
    send_request(OP_PUSH, 0, 16'hcafe, 64'h2);
    send_request(OP_CLEAR, 2, 16'h0, 64'h0);
    write_reg(REG_MASK, 8'h01);
    write_reg(REG_MAX_ENTRIES, 8'd2);
    send_request(OP_PUSH, 0, 16'hf00d, 64'h3);
    send_request(OP_CLEAR, 0, 16'h0, 64'h0);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MAX_ENTRIES, {3'd0, caps[ph]});
      write_reg(REG_DROP, {7'd0, ph[0] ^ ph[2]});
      write_reg(REG_MASK, ph == 0 ? 8'hff : ph == 3 ? 8'h00 : 8'($urandom));
      send_idle = (ph % 4 == 1) ? 88 : (ph % 4 == 3) ? 18 : 0;
      recv_stall = (ph % 4 == 2) ? 88 : (ph % 4 == 3) ? 18 : 0;
      if (ph == 4) hold_seq++;
      for (int i = 0; i < 230; i++) random_request();
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("covered %0d requests and %0d responses over 8 register settings",
             requests, responses);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (errors == 0)
      $display("PASS multi_reader_queue_evict_oldest_free_core");
    else
      $display("FAIL multi_reader_queue_evict_oldest_free_core");
    $finish;
  end

endmodule
